@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl files
// each macro expands to a labelled concurrent assertion, or to nothing in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/tvfl_pkg.sv @@
// ----------------------------------------------------------------------------
// tvfl_pkg
// types and constants shared by the timed value floor lookup block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tvfl_pkg;

  localparam int ENTRIES_DEF = 1024;
  localparam int CYCLE_W     = 32;
  localparam int OFFSET_W    = 16;
  localparam int VALUE_W     = 31;
  localparam int STATUS_W    = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // register index of base_cycle
  localparam logic [0:0] REG_BASE_CYCLE = 1'b0;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_UNDEF    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_ACCEPT   = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PROBE,
    BK_FETCH
  } bk_state_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [CYCLE_W-1:0] cycle;
    logic [VALUE_W-1:0]        entry_value;
    logic                      entry_defined;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [VALUE_W-1:0]        found_value;
    logic signed [CYCLE_W-1:0] set_at_cycle;
  } out_item_t;

  // classified request held between front and back
  typedef struct packed {
    req_kind_t           kind;
    logic [OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]  value;
    logic                defined;
  } cmd_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]  value;
    logic                defined;
  } entry_t;

endpackage

`default_nettype wire

@@ sv/timed_value_floor_lookup.sv @@
// append/clear: via queue and result register, one per cycle unless the output stalls
// lookup: queue, up to clog2(count+1) probes (11 at 1024), floor fetch, result register
// empty table or target before the first entry: answered from the queue head, no probe
// a lookup holds the back until done; the table has a single registered read port
// reset (rst_n low, synchronous): table empty, base_cycle 0, queue and output clear
// table contents are not cleared; only entries below the count are ever read
// ----------------------------------------------------------------------------
// timed_value_floor_lookup
// time-ordered value change table with append, clear and binary floor search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timed_value_floor_lookup #(
  parameter int ENTRIES = tvfl_pkg::ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tvfl_pkg::in_item_t                in_data,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tvfl_pkg::out_item_t                    out_data,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tvfl_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [tvfl_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tvfl_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import tvfl_pkg::*;

  // base_cycle register: the user writes it only while quiet; the block does not enforce it
  logic [CYCLE_W-1:0] base_cycle_r;
  logic               cfg_wr;

  // front to queue
  logic queue_full;
  logic push;
  cmd_t push_cmd;

  // queue to back
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  assign pready = 1'b1;

  // registers sit on word boundaries, so the index is the address above the byte lanes
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BASE_CYCLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cycle_r <= '0;
    end else if (cfg_wr) begin
      base_cycle_r <= pwdata;
    end
  end

  // read back: base_cycle at its address, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BASE_CYCLE) begin
      prdata = base_cycle_r;
    end
  end

  // front: decode the request, compute the 16-bit offset from the base
  tvfl_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .base_cycle (base_cycle_r),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // decoupling queue, lets the front take a transfer while the back is searching
  tvfl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: table memory, search sequencer and result register
  tvfl_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .base_cycle (base_cycle_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ sv/tvfl_front.sv @@
// ----------------------------------------------------------------------------
// tvfl_front
// accepts requests, decodes the type and reduces the cycle to an offset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvfl_front (
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire tvfl_pkg::in_item_t                 in_data,
  input  wire logic [tvfl_pkg::CYCLE_W-1:0]       base_cycle,
  input  wire logic                               queue_full,
  output logic                                    push,
  output tvfl_pkg::cmd_t                          push_cmd
);
  import tvfl_pkg::*;

  logic [CYCLE_W-1:0] diff;

  // offset wraps modulo 2^16
  assign diff = in_data.cycle - base_cycle;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_cmd         = '0;
    push_cmd.kind    = req_kind_t'(in_data.req_type);
    push_cmd.offset  = diff[OFFSET_W-1:0];
    push_cmd.value   = in_data.entry_value;
    push_cmd.defined = in_data.entry_defined;
  end

endmodule

`default_nettype wire

@@ sv/tvfl_queue.sv @@
// ----------------------------------------------------------------------------
// tvfl_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tvfl_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tvfl_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output tvfl_pkg::cmd_t      head_cmd
);
  import tvfl_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full       = (count_r == NW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `ASSERT_ALWAYS(a_q_count_bound, clk, rst_n, count_r <= NW'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_q_no_overflow, clk, rst_n, full, !push)
  `ASSERT_IMPLIES(a_q_no_underflow, clk, rst_n, !head_valid, !pop)

endmodule

`default_nettype wire

@@ sv/tvfl_back.sv @@
// ----------------------------------------------------------------------------
// tvfl_back
// owns the entry table, runs appends, clears and the floor search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tvfl_back #(
  parameter int ENTRIES = tvfl_pkg::ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [tvfl_pkg::CYCLE_W-1:0] base_cycle,
  input  wire logic                         head_valid,
  input  wire tvfl_pkg::cmd_t               head_cmd,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output tvfl_pkg::out_item_t               out_data
);
  import tvfl_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  bk_state_t state_r, state_nxt;

  entry_t              entry_mem_r [ENTRIES];
  entry_t              rdata_r;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  entry_t              wr_data;

  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  logic [OFFSET_W-1:0] target_r, target_nxt;
  logic [OFFSET_W-1:0] first_off_r;

  logic                out_valid_r;
  out_item_t           out_data_r;
  logic                res_load;
  out_item_t           res;
  logic                out_free;

  logic                le;
  logic [CW-1:0]       lo_adv, hi_adv;
  logic [CW:0]         mid_sum, first_sum;
  logic [AW-1:0]       mid_adv, mid_first;
  logic                go_on, is_full;
  logic                before_first;
  logic [CYCLE_W-1:0]  set_cycle;

  assign out_free = !out_valid_r || !out_stall;
  assign is_full  = (count_r == CW'(ENTRIES));

  // entry 0 offset is kept aside so a target below it is answered without a probe
  assign before_first = (head_cmd.offset < first_off_r);

  // one probe step from the entry read last cycle
  always_comb begin
    le        = (rdata_r.offset <= target_r);
    lo_adv    = le ? (CW'(mid_r) + CW'(1)) : lo_r;
    hi_adv    = le ? hi_r : CW'(mid_r);
    mid_sum   = {1'b0, lo_adv} + {1'b0, hi_adv};
    mid_adv   = mid_sum[AW:1];
    go_on     = (lo_adv < hi_adv);
    first_sum = {1'b0, count_r};
    mid_first = first_sum[AW:1];
    set_cycle = base_cycle + CYCLE_W'(rdata_r.offset);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head_valid && out_free && head_cmd.kind == REQ_LOOKUP && count_r != '0 &&
            !before_first) begin
          state_nxt = BK_PROBE;
        end
      end
      BK_PROBE: begin
        if (!go_on) begin
          if (lo_adv != '0) begin
            state_nxt = BK_FETCH;
          end else if (out_free) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_FETCH: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop        = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_data    = '0;
    res_load   = 1'b0;
    res        = '0;
    count_nxt  = count_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    target_nxt = target_r;
    case (state_r)
      BK_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          case (head_cmd.kind)
            REQ_APPEND: begin
              res_load = 1'b1;
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                wr_en           = 1'b1;
                wr_data.offset  = head_cmd.offset;
                wr_data.value   = head_cmd.value;
                wr_data.defined = head_cmd.defined;
                count_nxt       = count_r + CW'(1);
                res.status      = ST_ACCEPT;
              end
            end
            REQ_CLEAR: begin
              res_load   = 1'b1;
              count_nxt  = '0;
              res.status = ST_ACCEPT;
            end
            REQ_LOOKUP: begin
              // empty table or target before the first entry
              if (count_r == '0 || before_first) begin
                res_load   = 1'b1;
                res.status = ST_NOTFOUND;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = mid_first;
                lo_nxt     = '0;
                hi_nxt     = count_r;
                mid_nxt    = mid_first;
                target_nxt = head_cmd.offset;
              end
            end
            default: begin
              res_load   = 1'b1;
              res.status = ST_NOTFOUND;
            end
          endcase
        end
      end
      BK_PROBE: begin
        if (go_on) begin
          rd_en   = 1'b1;
          rd_addr = mid_adv;
          lo_nxt  = lo_adv;
          hi_nxt  = hi_adv;
          mid_nxt = mid_adv;
        end else if (lo_adv != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(lo_adv - CW'(1));
        end else if (out_free) begin
          res_load   = 1'b1;
          res.status = ST_NOTFOUND;
        end
      end
      BK_FETCH: begin
        if (out_free) begin
          res_load = 1'b1;
          if (rdata_r.defined) begin
            res.status       = ST_FOUND;
            res.found_value  = rdata_r.value;
            res.set_at_cycle = set_cycle;
          end else begin
            res.status = ST_UNDEF;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    target_r <= target_nxt;
    if (wr_en && count_r == '0) begin
      first_off_r <= wr_data.offset;
    end
    if (res_load) begin
      out_data_r <= res;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[count_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= entry_mem_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(ENTRIES))
  `ASSERT_IMPLIES(a_probe_window, clk, rst_n, state_r == BK_PROBE, lo_r < hi_r)
  `ASSERT_NEXT(a_clear_empties, clk, rst_n, pop && head_cmd.kind == REQ_CLEAR, count_r == '0)

endmodule

`default_nettype wire
